@@ hw/rtl/jts_pkg.sv @@
// jts_pkg: shared types, byte codes and token codes of the json token scanner
// no dependencies; used by all jts modules and the top level
`timescale 1ns / 1ps

package jts_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = 2;

   localparam logic [3:0] KIND_LBRACE = 4'd0;
   localparam logic [3:0] KIND_RBRACE = 4'd1;
   localparam logic [3:0] KIND_LBRACKET = 4'd2;
   localparam logic [3:0] KIND_RBRACKET = 4'd3;
   localparam logic [3:0] KIND_COLON = 4'd4;
   localparam logic [3:0] KIND_COMMA = 4'd5;
   localparam logic [3:0] KIND_TRUE = 4'd6;
   localparam logic [3:0] KIND_STRING = 4'd9;
   localparam logic [3:0] KIND_NUMBER = 4'd10;
   localparam logic [3:0] KIND_END = 4'd11;
   localparam logic [3:0] KIND_ERROR = 4'd12;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_BYTE = 2'd1;
   localparam logic [1:0] ERR_LITERAL = 2'd2;
   localparam logic [1:0] ERR_STRING = 2'd3;

   localparam logic [1:0] LIT_TRUE = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL = 2'd2;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef struct packed {
      logic [3:0]  kind;
      logic [1:0]  code;
      logic [15:0] start;
      logic [15:0] length;
   } tok_rec_type;

   typedef struct packed {
      logic [2:0]                         count;
      tok_rec_type [MAX_RESULTS-1:0]      recs;
   } tok_batch_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // remaining bytes of true / false / null after the first one
   function automatic logic [7:0] lit_char(logic [1:0] kind, logic [1:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      unique case ({kind, idx})
         {LIT_TRUE, 2'd0}:  ch = 8'h72;
         {LIT_TRUE, 2'd1}:  ch = 8'h75;
         {LIT_TRUE, 2'd2}:  ch = 8'h65;
         {LIT_FALSE, 2'd0}: ch = 8'h61;
         {LIT_FALSE, 2'd1}: ch = 8'h6C;
         {LIT_FALSE, 2'd2}: ch = 8'h73;
         {LIT_FALSE, 2'd3}: ch = 8'h65;
         {LIT_NULL, 2'd0}:  ch = 8'h75;
         {LIT_NULL, 2'd1}:  ch = 8'h6C;
         {LIT_NULL, 2'd2}:  ch = 8'h6C;
         default:           ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] lit_len(logic [1:0] kind);
      return (kind == LIT_FALSE) ? 3'd4 : 3'd3;
   endfunction

   function automatic tok_batch_type add_rec(tok_batch_type b, tok_rec_type r);
      tok_batch_type o;
      o = b;
      if (b.count < 3'(MAX_RESULTS)) begin
         o.recs[b.count[1:0]] = r;
         o.count = b.count + 3'd1;
      end
      return o;
   endfunction

endpackage

@@ hw/rtl/jts_front.sv @@
// jts_front: byte classifier and scan state; builds the batch of tokens one byte causes
// depends on jts_pkg
`timescale 1ns / 1ps

module jts_front #(
   parameter int POS_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  is_last,
   output logic                  push_valid,
   output jts_pkg::tok_batch_type push_data
);

   localparam int WB = (POS_BITS >= 16) ? POS_BITS + 1 : 17;

   typedef enum logic [2:0] {
      M_IDLE = 3'd0,
      M_LIT  = 3'd1,
      M_STR  = 3'd2,
      M_INT  = 3'd3,
      M_DOT  = 3'd4,
      M_FRAC = 3'd5,
      M_SKIP = 3'd6
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          index_ff, index_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] begin_ff, begin_in;

   function automatic logic [15:0] sat16(logic [WB-1:0] v);
      return (v > WB'(16'hFFFF)) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic jts_pkg::tok_rec_type mk(logic [3:0] kind, logic [1:0] code,
                                              logic [WB-1:0] start, logic [WB-1:0] stop);
      jts_pkg::tok_rec_type r;
      r.kind = kind;
      r.code = code;
      r.start = sat16(start);
      r.length = (stop > start) ? sat16(stop - start) : 16'd0;
      return r;
   endfunction

   logic [POS_BITS-1:0] nxt;
   logic [WB-1:0]       pw, p1, pm1, nw, bw, bw_new;
   logic [1:0]          k;
   logic [2:0]          nidx;
   logic                do_idle;
   jts_pkg::tok_batch_type b;

   always_comb begin
      nxt = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
      pw = WB'(pos_ff);
      p1 = pw + 1'b1;
      pm1 = (pos_ff == '0) ? '0 : pw - 1'b1;
      nw = WB'(nxt);
      bw = WB'(begin_ff);
      k = (kind_ff > jts_pkg::LIT_NULL) ? jts_pkg::LIT_NULL : kind_ff;
      nidx = {1'b0, index_ff} + 3'd1;
      mode_in = mode_ff;
      kind_in = kind_ff;
      index_in = index_ff;
      begin_in = begin_ff;
      pos_in = nxt;
      do_idle = 1'b0;
      b = '0;

      unique case (mode_ff)
         M_LIT: begin
            if (({1'b0, index_ff} < jts_pkg::lit_len(k)) &&
                (jts_pkg::lit_char(k, index_ff) == data_byte)) begin
               index_in = nidx[1:0];
               if (nidx >= jts_pkg::lit_len(k)) begin
                  b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_TRUE + {2'b00, k},
                                             jts_pkg::ERR_NONE, bw, p1));
                  mode_in = M_IDLE;
                  index_in = 2'd0;
               end
            end else begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_LITERAL, bw, p1));
               mode_in = M_SKIP;
            end
         end
         M_STR: begin
            if (data_byte == jts_pkg::CH_QUOTE) begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_STRING, jts_pkg::ERR_NONE, bw, pw));
               mode_in = M_IDLE;
            end
         end
         M_INT: begin
            if (data_byte == jts_pkg::CH_DOT) begin
               mode_in = M_DOT;
            end else if (!jts_pkg::is_digit(data_byte)) begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE, bw, pw));
               mode_in = M_IDLE;
               do_idle = 1'b1;
            end
         end
         M_DOT: begin
            if (jts_pkg::is_digit(data_byte)) begin
               mode_in = M_FRAC;
            end else begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE, bw, pm1));
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_BYTE, pm1, pw));
               mode_in = M_SKIP;
            end
         end
         M_FRAC: begin
            if (!jts_pkg::is_digit(data_byte)) begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE, bw, pw));
               mode_in = M_IDLE;
               do_idle = 1'b1;
            end
         end
         M_SKIP: begin
         end
         default: begin
            mode_in = M_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         unique case (data_byte) inside
            jts_pkg::CH_LBRACE:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_LBRACE, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_RBRACE:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_RBRACE, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_LBRACKET:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_LBRACKET, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_RBRACKET:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_RBRACKET, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_COLON:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_COLON, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_COMMA:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_COMMA, jts_pkg::ERR_NONE, pw, p1));
            jts_pkg::CH_T, jts_pkg::CH_F, jts_pkg::CH_N: begin
               mode_in = M_LIT;
               kind_in = (data_byte == jts_pkg::CH_T) ? jts_pkg::LIT_TRUE :
                         (data_byte == jts_pkg::CH_F) ? jts_pkg::LIT_FALSE : jts_pkg::LIT_NULL;
               index_in = 2'd0;
               begin_in = pos_ff;
            end
            jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR: begin
            end
            jts_pkg::CH_QUOTE: begin
               mode_in = M_STR;
               begin_in = nxt;
            end
            default: begin
               if ((data_byte == jts_pkg::CH_MINUS) || jts_pkg::is_digit(data_byte)) begin
                  mode_in = M_INT;
                  begin_in = pos_ff;
               end else begin
                  b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_BYTE, pw, p1));
                  mode_in = M_SKIP;
               end
            end
         endcase
      end

      bw_new = WB'(begin_in);
      if (is_last) begin
         unique case (mode_in)
            M_LIT:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_LITERAL, bw_new, p1));
            M_STR:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_STRING, bw_new, p1));
            M_INT, M_FRAC:
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE, bw_new, p1));
            M_DOT: begin
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE, bw_new, pw));
               b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_ERROR, jts_pkg::ERR_BYTE, pw, p1));
            end
            default: begin
            end
         endcase
         b = jts_pkg::add_rec(b, mk(jts_pkg::KIND_END, jts_pkg::ERR_NONE, nw, nw));
         mode_in = M_IDLE;
         kind_in = 2'd0;
         index_in = 2'd0;
         pos_in = '0;
         begin_in = '0;
      end
   end

   assign push_valid = accept && (b.count != 3'd0);
   assign push_data = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         kind_ff <= 2'd0;
         index_ff <= 2'd0;
         pos_ff <= '0;
         begin_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kind_ff <= kind_in;
         index_ff <= index_in;
         pos_ff <= pos_in;
         begin_ff <= begin_in;
      end
   end

endmodule

@@ hw/rtl/jts_queue.sv @@
// jts_queue: short queue of token batches between front and back
// depends on jts_pkg
`timescale 1ns / 1ps

module jts_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  jts_pkg::tok_batch_type      push_data,
   input  logic                        pop,
   output jts_pkg::tok_batch_type      head,
   output jts_pkg::queue_status_type   status
);

   jts_pkg::tok_batch_type mem [jts_pkg::QUEUE_DEPTH];

   logic [jts_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jts_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jts_pkg::QPTR_BITS:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign status.full = (count_ff == (jts_pkg::QPTR_BITS + 1)'(jts_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/jts_back.sv @@
// jts_back: walks the head batch one token at a time into the output register
// depends on jts_pkg
`timescale 1ns / 1ps

module jts_back (
   input  logic                        clock,
   input  logic                        reset,
   input  jts_pkg::tok_batch_type      head,
   input  jts_pkg::queue_status_type   status,
   output logic                        pop,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_token_kind,
   output logic [1:0]                  rsp_error_code,
   output logic [15:0]                 rsp_token_start,
   output logic [15:0]                 rsp_token_length,
   output logic                        rsp_last_result
);

   logic [1:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   jts_pkg::tok_rec_type rec_ff, rec_in;
   logic                 last_ff, last_in;
   logic                 load, take, is_end;

   assign load = !valid_ff || !rsp_stall;
   assign take = load && !status.empty;
   assign is_end = ({1'b0, idx_ff} + 3'd1) >= head.count;
   assign pop = take && is_end;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      rec_in = rec_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = !status.empty;
         if (take) begin
            rec_in = head.recs[idx_ff];
            last_in = is_end;
            idx_in = is_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_token_kind = rec_ff.kind;
   assign rsp_error_code = rec_ff.code;
   assign rsp_token_start = rec_ff.start;
   assign rsp_token_length = rec_ff.length;
   assign rsp_last_result = last_ff;

endmodule

@@ hw/rtl/json_token_scanner.sv @@
// json_token_scanner: top level of the byte-serial json lexer
// depends on jts_pkg, jts_front, jts_queue, jts_back
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  data_byte, is_last
//   rsp      out        rsp_valid/rsp_stall  token_kind, error_code, token_start,
//                                            token_length, last_result
//
// one byte per cycle is taken while the batch queue (4 entries) has room
// each byte that yields k tokens (k up to 3) presents them on the output register one at a time, in order
// the first token of an accepted byte is written into the batch queue and then loaded into the output register
// reset is synchronous; no clearing pass
// req_stall rises only when the batch queue is full
`timescale 1ns / 1ps

module json_token_scanner #(
   parameter int POS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_result
);

   jts_pkg::tok_batch_type    push_data, head;
   jts_pkg::queue_status_type status;
   logic                      accept, push_valid, pop;

   assign req_stall = status.full;
   assign accept = req_valid && !status.full;

   jts_front #(
      .POS_BITS(POS_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data_byte(req_data_byte),
      .is_last(req_is_last),
      .push_valid(push_valid),
      .push_data(push_data)
   );

   jts_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_data(push_data),
      .pop(pop),
      .head(head),
      .status(status)
   );

   jts_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .status(status),
      .pop(pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_token_kind(rsp_token_kind),
      .rsp_error_code(rsp_error_code),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_result(rsp_last_result)
   );

endmodule
